// ===== design/mbf_pkg.sv =====
// Shared types, codes, limits and the CRC byte update for the Modbus RTU request framer.
package mbf_pkg;

    // Request opcodes as they arrive on the input channel.
    localparam logic [3:0] OP_RD_COILS  = 4'd0;
    localparam logic [3:0] OP_RD_DISC   = 4'd1;
    localparam logic [3:0] OP_RD_HOLD   = 4'd2;
    localparam logic [3:0] OP_RD_INPUT  = 4'd3;
    localparam logic [3:0] OP_WR_COIL   = 4'd4;
    localparam logic [3:0] OP_WR_REG    = 4'd5;
    localparam logic [3:0] OP_WR_COILS  = 4'd6;
    localparam logic [3:0] OP_WR_REGS   = 4'd7;
    localparam logic [3:0] OP_DATA      = 4'd8;

    // Pending multiple-write kinds.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_COILS = 2'd1;
    localparam logic [1:0] PEND_REGS  = 2'd2;

    // Quantity limits.
    localparam int MAX_WRITE_COILS_DEF = 1968;
    localparam int MAX_WRITE_REGS_DEF  = 123;
    localparam logic [15:0] READ_BIT_LIMIT = 16'd2000;
    localparam logic [15:0] READ_REG_LIMIT = 16'd125;

    localparam int ELEM_W     = 11;
    localparam int CMD_BYTES  = 7;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One work command handed from the front end to the byte sequencer.
    typedef struct packed {
        logic                           err;
        logic                           crc_init;
        logic                           add_crc;
        logic [2:0]                     nbytes;
        logic [CMD_BYTES-1:0][7:0]      bytes;
    } cmd_t;

    function automatic logic [7:0] fcode(input logic [2:0] op);
        logic [7:0] code;
        case (op)
            3'd0:    code = 8'h01;
            3'd1:    code = 8'h02;
            3'd2:    code = 8'h03;
            3'd3:    code = 8'h04;
            3'd4:    code = 8'h05;
            3'd5:    code = 8'h06;
            3'd6:    code = 8'h0F;
            default: code = 8'h10;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/mbf_front.sv =====
// Front end: accepts request beats, tracks the open frame and emits byte commands.
module mbf_front #(
    parameter int MAX_WRITE_COILS = mbf_pkg::MAX_WRITE_COILS_DEF,
    parameter int MAX_WRITE_REGS  = mbf_pkg::MAX_WRITE_REGS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [3:0]   s_opcode,
    input  logic [7:0]   s_slave_addr,
    input  logic [15:0]  s_start_addr,
    input  logic [15:0]  s_quantity,
    input  logic [15:0]  s_element_value,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output mbf_pkg::cmd_t cmd
);
    import mbf_pkg::*;

    logic [1:0]        pend_reg, pend_next;
    logic [ELEM_W-1:0] left_reg, left_next;
    logic [7:0]        pack_reg, pack_next;
    logic [2:0]        idx_reg, idx_next;

    logic              accept;
    logic              check;
    logic              bad;
    logic [15:0]       limit;
    logic [16:0]       qty_plus7;
    logic [ELEM_W-1:0] left_dec;
    logic [7:0]        pack_or;
    logic [2:0]        idx_inc;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;

    assign qty_plus7 = {1'b0, s_quantity} + 17'd7;
    assign left_dec  = left_reg - ELEM_W'(1);
    assign pack_or   = pack_reg | ((s_element_value != 16'd0) ? (8'h01 << idx_reg) : 8'h00);
    assign idx_inc   = idx_reg + 3'd1;

    always_comb begin
        check = 1'b0;
        limit = 16'd0;
        unique case (s_opcode) inside
            OP_RD_COILS, OP_RD_DISC: begin
                check = 1'b1;
                limit = READ_BIT_LIMIT;
            end
            OP_RD_HOLD, OP_RD_INPUT: begin
                check = 1'b1;
                limit = READ_REG_LIMIT;
            end
            OP_WR_COILS: begin
                check = 1'b1;
                limit = 16'(MAX_WRITE_COILS);
            end
            OP_WR_REGS: begin
                check = 1'b1;
                limit = 16'(MAX_WRITE_REGS);
            end
            default: begin
                check = 1'b0;
                limit = 16'd0;
            end
        endcase
    end

    assign bad = check && ((s_quantity == 16'd0) || (s_quantity > limit));

    always_comb begin
        cmd       = '0;
        pend_next = pend_reg;
        left_next = left_reg;
        pack_next = pack_reg;
        idx_next  = idx_reg;
        if (s_opcode > OP_DATA) begin
            cmd.err = 1'b1;
        end else if (s_opcode == OP_DATA) begin
            if (pend_reg == PEND_NONE || left_reg == '0) begin
                cmd.err = 1'b1;
            end else begin
                left_next = left_dec;
                if (pend_reg == PEND_COILS) begin
                    if (idx_inc == 3'd0 || left_dec == '0) begin
                        cmd.bytes[0] = pack_or;
                        cmd.nbytes   = 3'd1;
                        pack_next    = 8'h00;
                        idx_next     = 3'd0;
                    end else begin
                        pack_next = pack_or;
                        idx_next  = idx_inc;
                    end
                end else begin
                    cmd.bytes[0] = s_element_value[15:8];
                    cmd.bytes[1] = s_element_value[7:0];
                    cmd.nbytes   = 3'd2;
                end
                if (left_dec == '0) begin
                    cmd.add_crc = 1'b1;
                    pend_next   = PEND_NONE;
                end
            end
        end else begin
            // A new header abandons any unfinished frame.
            pend_next    = PEND_NONE;
            left_next    = '0;
            pack_next    = 8'h00;
            idx_next     = 3'd0;
            cmd.crc_init = 1'b1;
            if (bad) begin
                cmd.err = 1'b1;
            end else begin
                cmd.bytes[0] = s_slave_addr;
                cmd.bytes[1] = fcode(s_opcode[2:0]);
                cmd.bytes[2] = s_start_addr[15:8];
                cmd.bytes[3] = s_start_addr[7:0];
                cmd.nbytes   = 3'd6;
                cmd.add_crc  = 1'b1;
                if (s_opcode == OP_WR_COIL) begin
                    cmd.bytes[4] = (s_quantity != 16'd0) ? 8'hFF : 8'h00;
                    cmd.bytes[5] = 8'h00;
                end else begin
                    cmd.bytes[4] = s_quantity[15:8];
                    cmd.bytes[5] = s_quantity[7:0];
                end
                if (s_opcode == OP_WR_COILS) begin
                    cmd.bytes[6] = qty_plus7[10:3];
                    cmd.nbytes   = 3'd7;
                    cmd.add_crc  = 1'b0;
                    pend_next    = PEND_COILS;
                    left_next    = s_quantity[ELEM_W-1:0];
                end else if (s_opcode == OP_WR_REGS) begin
                    cmd.bytes[6] = {s_quantity[6:0], 1'b0};
                    cmd.nbytes   = 3'd7;
                    cmd.add_crc  = 1'b0;
                    pend_next    = PEND_REGS;
                    left_next    = s_quantity[ELEM_W-1:0];
                end
            end
        end
    end

    // Coil beats that only add a bit to the packing byte need no command.
    assign cmd_valid = accept && (cmd.err || cmd.crc_init || cmd.add_crc || (cmd.nbytes != 3'd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
            left_reg <= '0;
            pack_reg <= 8'h00;
            idx_reg  <= 3'd0;
        end else if (accept) begin
            pend_reg <= pend_next;
            left_reg <= left_next;
            pack_reg <= pack_next;
            idx_reg  <= idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == PEND_NONE |-> left_reg == '0 && pack_reg == 8'h00 && idx_reg == 3'd0)
        else $error("front: counters not clear without an open write");
    a_regs_no_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == PEND_REGS |-> pack_reg == 8'h00 && idx_reg == 3'd0 && left_reg != '0)
        else $error("front: register write holds coil packing state");
    a_stray_err: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_opcode == OP_DATA && pend_reg == PEND_NONE |-> cmd_valid && cmd.err)
        else $error("front: stray data beat did not raise an error command");
`endif

endmodule

// ===== design/mbf_queue.sv =====
// Two-entry command queue between the front end and the byte sequencer.
module mbf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  mbf_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output mbf_pkg::cmd_t out_cmd
);
    import mbf_pkg::*;

    cmd_t e0_reg, e0_next, e1_reg, e1_next;
    logic v0_reg, v0_next, v1_reg, v1_next;
    logic push, pop;

    assign in_ready  = !v1_reg;
    assign out_valid = v0_reg;
    assign out_cmd   = e0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = v0_reg && out_ready;

    always_comb begin
        e0_next = e0_reg;
        e1_next = e1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (pop) begin
            e0_next = e1_reg;
            v0_next = v1_reg;
            v1_next = 1'b0;
        end
        if (push) begin
            if (!v0_next) begin
                e0_next = in_cmd;
                v0_next = 1'b1;
            end else begin
                e1_next = in_cmd;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

`ifndef ASSERT_OFF
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> v0_reg)
        else $error("queue: second entry valid without the first");
    a_keep_head: assert property (@(posedge aclk) disable iff (!aresetn)
        v0_reg && !out_ready |=> v0_reg && $stable(e0_reg))
        else $error("queue: head changed without being taken");
    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && v0_reg |=> v1_reg)
        else $error("queue: pushed command did not land in the second entry");
`endif

endmodule

// ===== design/mbf_back.sv =====
// Back end: plays out command bytes one per cycle while the receiver is ready, folds them into the CRC and appends it.
module mbf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  mbf_pkg::cmd_t q_cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_byte,
    output logic          m_last_byte,
    output logic          m_request_error
);
    import mbf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DATA   = 5'b00010,
        ST_CRC_LO = 5'b00100,
        ST_CRC_HI = 5'b01000,
        ST_ERR    = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CMD_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [2:0]                left_reg, left_next;
    logic                      add_crc_reg, add_crc_next;
    logic [15:0]               crc_reg, crc_next;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      last_reg, last_next;
    logic                      err_reg, err_next;

    logic adv, emit, final_beat, load;

    // The output register can take a beat when it is empty or being drained.
    assign adv = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        bytes_next   = bytes_reg;
        left_next    = left_reg;
        add_crc_next = add_crc_reg;
        crc_next     = crc_reg;
        emit         = 1'b0;
        final_beat   = 1'b0;
        byte_next    = byte_reg;
        last_next    = 1'b0;
        err_next     = 1'b0;
        if (adv) begin
            unique case (state_reg)
                ST_IDLE: begin
                    emit = 1'b0;
                end
                ST_ERR: begin
                    emit       = 1'b1;
                    byte_next  = 8'h00;
                    last_next  = 1'b1;
                    err_next   = 1'b1;
                    final_beat = 1'b1;
                end
                ST_DATA: begin
                    emit       = 1'b1;
                    byte_next  = bytes_reg[0];
                    crc_next   = crc_byte(crc_reg, bytes_reg[0]);
                    bytes_next = {8'h00, bytes_reg[CMD_BYTES-1:1]};
                    left_next  = left_reg - 3'd1;
                    if (left_reg == 3'd1) begin
                        if (add_crc_reg) begin
                            state_next = ST_CRC_LO;
                        end else begin
                            final_beat = 1'b1;
                        end
                    end
                end
                ST_CRC_LO: begin
                    emit       = 1'b1;
                    byte_next  = crc_reg[7:0];
                    state_next = ST_CRC_HI;
                end
                ST_CRC_HI: begin
                    emit       = 1'b1;
                    byte_next  = crc_reg[15:8];
                    last_next  = 1'b1;
                    crc_next   = CRC_INIT;
                    final_beat = 1'b1;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        if (final_beat) begin
            state_next = ST_IDLE;
        end
        load = q_valid && (state_reg == ST_IDLE || final_beat);
        if (load) begin
            bytes_next   = q_cmd.bytes;
            left_next    = q_cmd.nbytes;
            add_crc_next = q_cmd.add_crc;
            if (q_cmd.crc_init) begin
                crc_next = CRC_INIT;
            end
            if (q_cmd.err) begin
                state_next = ST_ERR;
            end else if (q_cmd.nbytes != 3'd0) begin
                state_next = ST_DATA;
            end else if (q_cmd.add_crc) begin
                state_next = ST_CRC_LO;
            end else begin
                state_next = ST_IDLE;
            end
        end
        m_valid_next = adv ? emit : m_valid_reg;
    end

    assign q_ready = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
        bytes_reg   <= bytes_next;
        left_reg    <= left_next;
        add_crc_reg <= add_crc_next;
        if (emit) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = byte_reg;
    assign m_last_byte     = last_reg;
    assign m_request_error = err_reg;

`ifndef ASSERT_OFF
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_request_error |-> m_last_byte && m_frame_byte == 8'h00)
        else $error("back: error beat is not a lone zero end beat");
    a_crc_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && state_reg == ST_CRC_HI |=> crc_reg == CRC_INIT)
        else $error("back: CRC not rearmed after frame end");
    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DATA |-> left_reg != 3'd0)
        else $error("back: data state with no bytes left");
`endif

endmodule

// ===== design/modbus_rtu_request_framer.sv =====
// Top level of the Modbus RTU master request framer: front end, command queue, byte sequencer.
// A result beat is registered in the queue, then in the sequencer state, then in the output register.
// Throughput: one result beat per cycle while the receiver is ready; a read or single write header yields 8 beats.
// A header behind a draining frame waits in a two-entry queue; input stalls once it is full.
// The byte sequencer's one-beat-per-cycle CRC update sets the sustained rate while the receiver is ready.
// Reset (aresetn, synchronous, active low) drops any open frame and rearms the CRC to FFFF.
module modbus_rtu_request_framer #(
    parameter int MAX_WRITE_COILS = mbf_pkg::MAX_WRITE_COILS_DEF,
    parameter int MAX_WRITE_REGS  = mbf_pkg::MAX_WRITE_REGS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [7:0]  s_slave_addr,
    input  logic [15:0] s_start_addr,
    input  logic [15:0] s_quantity,
    input  logic [15:0] s_element_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_last_byte,
    output logic        m_request_error
);
    import mbf_pkg::*;

    // The front end decodes each request beat and keeps the state of an
    // open multiple-write frame: pending kind, elements still owed, and the
    // coil byte being packed. Each beat that produces output becomes one
    // command holding up to seven frame bytes plus CRC and error flags.
    cmd_t fq_cmd;
    logic fq_valid, fq_ready;

    // The queue lets the front end keep taking beats while the sequencer is
    // still playing out an earlier frame.
    cmd_t qb_cmd;
    logic qb_valid, qb_ready;

    mbf_front #(
        .MAX_WRITE_COILS (MAX_WRITE_COILS),
        .MAX_WRITE_REGS  (MAX_WRITE_REGS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_slave_addr    (s_slave_addr),
        .s_start_addr    (s_start_addr),
        .s_quantity      (s_quantity),
        .s_element_value (s_element_value),
        .cmd_valid       (fq_valid),
        .cmd_ready       (fq_ready),
        .cmd             (fq_cmd)
    );

    mbf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // The sequencer sends one byte per beat, folding each into the running
    // CRC, and ends a frame with the CRC low byte then high byte.
    mbf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_cmd           (qb_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_last_byte     (m_last_byte),
        .m_request_error (m_request_error)
    );

endmodule

// ===== dv/modbus_rtu_request_framer_checker.sv =====
// Checker for the Modbus RTU request framer: predicts every frame beat and compares it.
`timescale 1ns / 1ps
module modbus_rtu_request_framer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [7:0]  s_slave_addr,
    input  logic [15:0] s_start_addr,
    input  logic [15:0] s_quantity,
    input  logic [15:0] s_element_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_frame_byte,
    input  logic        m_last_byte,
    input  logic        m_request_error,
    output int          fail_count,
    output int          beats_owed
);
    import mbf_pkg::*;

    // Modbus function codes as they appear on the wire.
    localparam logic [7:0] FC_RD_COILS = 8'h01;
    localparam logic [7:0] FC_RD_DISC  = 8'h02;
    localparam logic [7:0] FC_RD_HOLD  = 8'h03;
    localparam logic [7:0] FC_RD_INPUT = 8'h04;
    localparam logic [7:0] FC_WR_COIL  = 8'h05;
    localparam logic [7:0] FC_WR_REG   = 8'h06;
    localparam logic [7:0] FC_WR_COILS = 8'h0F;
    localparam logic [7:0] FC_WR_REGS  = 8'h10;
    localparam logic [7:0] COIL_ON     = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } frame_beat_t;

    frame_beat_t        frame_bytes_due[$];
    frame_beat_t        head;
    logic [15:0]        crc_run;
    logic [1:0]         open_write;
    logic [ELEM_W-1:0]  elems_owed;
    logic [7:0]         coil_byte;
    logic [2:0]         coil_pos;
    int                 misses = 0;

    // Reflected CRC-16, one message bit at a time.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        crc_run = crc_fold(crc_run, b);
        frame_bytes_due.push_back('{data: b, last: 1'b0, err: 1'b0});
    endfunction

    function automatic void push_crc();
        frame_bytes_due.push_back('{data: crc_run[7:0], last: 1'b0, err: 1'b0});
        frame_bytes_due.push_back('{data: crc_run[15:8], last: 1'b1, err: 1'b0});
        crc_run = CRC_INIT;
    endfunction

    function automatic void push_error();
        frame_bytes_due.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
    endfunction

    function automatic void predict_frame(input logic [3:0] op, input logic [7:0] addr,
                                          input logic [15:0] start, input logic [15:0] qty,
                                          input logic [15:0] elem);
        int          lim;
        logic        checked;
        logic [7:0]  fc;
        logic [16:0] coil_bytes;
        lim = 0;
        checked = 1'b1;
        fc = FC_WR_REGS;
        if (op > OP_DATA) begin
            push_error();
        end else if (op == OP_DATA) begin
            if (open_write == PEND_NONE || elems_owed == '0) begin
                push_error();
            end else begin
                elems_owed = elems_owed - ELEM_W'(1);
                if (open_write == PEND_COILS) begin
                    if (elem != 16'h0000) begin
                        coil_byte[coil_pos] = 1'b1;
                    end
                    coil_pos = coil_pos + 3'd1;
                    if (coil_pos == 3'd0 || elems_owed == '0) begin
                        push_byte(coil_byte);
                        coil_byte = '0;
                        coil_pos = '0;
                    end
                end else begin
                    push_byte(elem[15:8]);
                    push_byte(elem[7:0]);
                end
                if (elems_owed == '0) begin
                    push_crc();
                    open_write = PEND_NONE;
                end
            end
        end else begin
            // A new header always drops whatever frame was still open.
            open_write = PEND_NONE;
            elems_owed = '0;
            coil_byte = '0;
            coil_pos = '0;
            crc_run = CRC_INIT;
            case (op)
                OP_RD_COILS: begin lim = int'(READ_BIT_LIMIT); fc = FC_RD_COILS; end
                OP_RD_DISC:  begin lim = int'(READ_BIT_LIMIT); fc = FC_RD_DISC;  end
                OP_RD_HOLD:  begin lim = int'(READ_REG_LIMIT); fc = FC_RD_HOLD;  end
                OP_RD_INPUT: begin lim = int'(READ_REG_LIMIT); fc = FC_RD_INPUT; end
                OP_WR_COIL:  begin checked = 1'b0;             fc = FC_WR_COIL;  end
                OP_WR_REG:   begin checked = 1'b0;             fc = FC_WR_REG;   end
                OP_WR_COILS: begin lim = MAX_WRITE_COILS_DEF;  fc = FC_WR_COILS; end
                default:     begin lim = MAX_WRITE_REGS_DEF;   fc = FC_WR_REGS;  end
            endcase
            if (checked && (qty == 16'h0000 || int'(qty) > lim)) begin
                push_error();
            end else begin
                push_byte(addr);
                push_byte(fc);
                push_byte(start[15:8]);
                push_byte(start[7:0]);
                if (op == OP_WR_COIL) begin
                    push_byte(qty != 16'h0000 ? COIL_ON : 8'h00);
                    push_byte(8'h00);
                    push_crc();
                end else begin
                    push_byte(qty[15:8]);
                    push_byte(qty[7:0]);
                    if (op == OP_WR_COILS) begin
                        coil_bytes = ({1'b0, qty} + 17'd7) >> 3;
                        push_byte(coil_bytes[7:0]);
                        open_write = PEND_COILS;
                        elems_owed = qty[ELEM_W-1:0];
                    end else if (op == OP_WR_REGS) begin
                        push_byte({qty[6:0], 1'b0});
                        open_write = PEND_REGS;
                        elems_owed = qty[ELEM_W-1:0];
                    end else begin
                        push_crc();
                    end
                end
            end
        end
    endfunction

    // Results are compared before the new request is predicted; since the framer registers every
    // result, a result beat can never belong to the request taken at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_due.delete();
            crc_run = CRC_INIT;
            open_write = PEND_NONE;
            elems_owed = '0;
            coil_byte = '0;
            coil_pos = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected result beat: actual byte %02h last %0b error %0b",
                             $time, m_frame_byte, m_last_byte, m_request_error);
                    misses++;
                end else begin
                    head = frame_bytes_due.pop_front();
                    if (m_frame_byte !== head.data) begin
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, head.data, m_frame_byte);
                        misses++;
                    end
                    if (m_last_byte !== head.last) begin
                        $display("%0t: last_byte expected %0b actual %0b",
                                 $time, head.last, m_last_byte);
                        misses++;
                    end
                    if (m_request_error !== head.err) begin
                        $display("%0t: request_error expected %0b actual %0b",
                                 $time, head.err, m_request_error);
                        misses++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_frame(s_opcode, s_slave_addr, s_start_addr, s_quantity, s_element_value);
            end
        end
        fail_count <= misses;
        beats_owed <= frame_bytes_due.size();
    end

endmodule

// ===== dv/modbus_rtu_request_framer_tb.sv =====
// Testbench top for the Modbus RTU request framer: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module modbus_rtu_request_framer_tb;
    import mbf_pkg::*;

    // Requests taken by the random part of the run.
    localparam int RANDOM_BEATS      = 130;
    // The receiver holds off this long once, so the framer fills up and stalls its input.
    localparam int SINK_HOLD_CYCLES  = 300;
    // Cycles allowed after the last expected beat, for anything stray to show up.
    localparam int TAIL_CYCLES       = 16;
    // Hard stop in ns; several times the slowest correct run.
    localparam int RUN_LIMIT_NS      = 5_000_000;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [3:0]  s_opcode        = '0;
    logic [7:0]  s_slave_addr    = '0;
    logic [15:0] s_start_addr    = '0;
    logic [15:0] s_quantity      = '0;
    logic [15:0] s_element_value = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_last_byte;
    logic        m_request_error;

    int          fail_count;
    int          beats_owed;
    int          beats_sent      = 0;
    logic        sink_hold_req   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    modbus_rtu_request_framer i_dut (.*);

    modbus_rtu_request_framer_checker i_checker (.*);

    // Idle lengths for both channels: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Largest legal quantity for an opcode; single writes carry a value and are never checked.
    function automatic int qty_limit(input logic [3:0] op);
        case (op) inside
            OP_RD_COILS, OP_RD_DISC: return int'(READ_BIT_LIMIT);
            OP_RD_HOLD, OP_RD_INPUT: return int'(READ_REG_LIMIT);
            OP_WR_COILS:             return MAX_WRITE_COILS_DEF;
            OP_WR_REGS:              return MAX_WRITE_REGS_DEF;
            default:                 return 65535;
        endcase
    endfunction

    // Half of the coil beats are off; the rest carry any nonzero-ish value.
    function automatic logic [15:0] coil_value();
        return $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
    endfunction

    // Offers one request beat and returns at the edge where it is taken. Valid is only
    // dropped when an idle gap follows, so back-to-back beats keep it high throughout.
    task automatic offer_beat(input logic [3:0] op, input logic [7:0] addr,
                              input logic [15:0] start, input logic [15:0] qty,
                              input logic [15:0] elem, input bit gapless);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_slave_addr    <= addr;
        s_start_addr    <= start;
        s_quantity      <= qty;
        s_element_value <= elem;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Header beat with random address fields; the element field is noise here.
    task automatic send_header(input logic [3:0] op, input logic [15:0] qty, input bit gapless);
        offer_beat(op, 8'($urandom), 16'($urandom), qty, 16'($urandom), gapless);
    endtask

    // Data beat; every other field is noise that the framer must ignore.
    task automatic send_data(input logic [15:0] elem, input bit gapless);
        offer_beat(OP_DATA, 8'($urandom), 16'($urandom), 16'($urandom), elem, gapless);
    endtask

    // Receiver pacing. Runs of ready alternate with random stalls; a request from the
    // stimulus turns the next stall into one long hold-off, counted out here.
    initial begin : sink_pacing
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int         pick;
        int         n;
        int         rand_goal;
        bit         gapless;
        logic [3:0] op;
        logic [15:0] qty;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Reads at the field extremes and on both sides of each limit.
        offer_beat(OP_RD_COILS, 8'h00, 16'h0000, 16'd1, 16'h0000, 1'b0);
        offer_beat(OP_RD_DISC, 8'hFF, 16'hFFFF, READ_BIT_LIMIT, 16'hFFFF, 1'b0);
        send_header(OP_RD_DISC, READ_BIT_LIMIT + 16'd1, 1'b0);
        send_header(OP_RD_HOLD, READ_REG_LIMIT, 1'b0);
        send_header(OP_RD_INPUT, READ_REG_LIMIT + 16'd1, 1'b0);
        // Single writes: a nonzero coil value goes out as FF 00, zero as 00 00.
        send_header(OP_WR_COIL, 16'h1234, 1'b0);
        send_header(OP_WR_COIL, 16'h0000, 1'b0);
        send_header(OP_WR_REG, 16'hFFFF, 1'b0);
        // A data beat with no open write, and an opcode past the data opcode.
        send_data(16'h5A5A, 1'b0);
        send_header(4'hF, 16'hFFFF, 1'b0);
        // Nine coils: one full packed byte, then a partial one closed by the last coil.
        send_header(OP_WR_COILS, 16'd9, 1'b0);
        send_data(16'h0001, 1'b0);
        send_data(16'h0000, 1'b0);
        send_data(16'hFFFF, 1'b0);
        send_data(16'h0000, 1'b0);
        send_data(16'h8000, 1'b0);
        send_data(16'h0000, 1'b0);
        send_data(16'h0000, 1'b0);
        send_data(16'h0001, 1'b1);
        send_data(16'h0100, 1'b1);
        // One register written in full.
        send_header(OP_WR_REGS, 16'd1, 1'b0);
        send_data(16'hFFFF, 1'b0);
        // Multiple writes with zero and too-large counts.
        send_header(OP_WR_COILS, 16'd0, 1'b0);
        send_header(OP_WR_REGS, 16'(MAX_WRITE_REGS_DEF + 1), 1'b0);
        // Largest legal multiple writes, each abandoned by the header after it.
        send_header(OP_WR_COILS, 16'(MAX_WRITE_COILS_DEF), 1'b0);
        send_data(16'hFFFF, 1'b0);
        send_header(OP_WR_REGS, 16'(MAX_WRITE_REGS_DEF), 1'b0);

        // Random part. It opens with a burst of reads into a long receiver hold-off,
        // so the framer's queue fills and it has to stall its input.
        rand_goal = beats_sent + RANDOM_BEATS;
        sink_hold_req = 1'b1;
        repeat (12) begin
            send_header(OP_RD_HOLD, 16'($urandom_range(1, READ_REG_LIMIT)), 1'b1);
        end

        while (beats_sent < rand_goal) begin
            pick = $urandom_range(0, 99);
            gapless = ($urandom_range(0, 3) == 0);
            if (pick < 25) begin
                // Read or single write with a legal quantity.
                op = 4'($urandom_range(0, 5));
                qty = (op == OP_WR_COIL || op == OP_WR_REG) ? 16'($urandom)
                    : 16'($urandom_range(1, qty_limit(op)));
                send_header(op, qty, gapless);
            end else if (pick < 55) begin
                // Complete coil write, mostly short.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
                send_header(OP_WR_COILS, 16'(n), gapless);
                repeat (n) send_data(coil_value(), gapless);
            end else if (pick < 75) begin
                // Complete register write.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_header(OP_WR_REGS, 16'(n), gapless);
                repeat (n) send_data(16'($urandom), gapless);
            end else if (pick < 83) begin
                // Write cut short; the next header abandons it.
                op = $urandom_range(0, 1) ? OP_WR_COILS : OP_WR_REGS;
                n = $urandom_range(2, 10);
                send_header(op, 16'(n), gapless);
                repeat ($urandom_range(0, n - 1)) begin
                    send_data(op == OP_WR_COILS ? coil_value() : 16'($urandom), gapless);
                end
            end else if (pick < 90) begin
                // Data beat, stray unless a cut-short write is still open.
                send_data(16'($urandom), gapless);
            end else if (pick < 95) begin
                send_header(4'($urandom_range(9, 15)), 16'($urandom), gapless);
            end else begin
                // Quantity out of range for a read or a multiple write.
                op = $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                   : ($urandom_range(0, 1) ? OP_WR_COILS : OP_WR_REGS);
                qty = $urandom_range(0, 1) ? 16'h0000
                    : 16'($urandom_range(qty_limit(op) + 1, 65535));
                send_header(op, qty, gapless);
            end
        end
        s_valid <= 1'b0;

        // The checker's count is registered, so step past the last accepted request
        // before waiting for the expected beats to drain.
        @(posedge aclk);
        while (beats_owed != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && beats_owed == 0) begin
            $display("modbus_rtu_request_framer_tb: PASS");
        end else begin
            $display("modbus_rtu_request_framer_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("modbus_rtu_request_framer_tb: FAIL");
        $finish;
    end

endmodule
